/* sv/fba_pkg.sv */
// Shared types, codes and constants for the fixed block stack allocator.
`timescale 1ns / 1ps
`default_nettype none

package fba_pkg;

    localparam int MAX_BLOCKS_DEF  = 1024;
    localparam int OFFSET_BITS_DEF = 24;

    // width of the buffer and block size registers, and of the divider
    localparam int DIV_W      = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES  = 2'd2;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_INIT  = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_CONFIG  = 3'd1;
    localparam logic [2:0] ST_EMPTY       = 3'd2;
    localparam logic [2:0] ST_BAD_ADDRESS = 3'd3;
    localparam logic [2:0] ST_ALL_FREE    = 3'd4;

    typedef logic [10:0] free_count_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] block_address;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] given_address;
        free_count_t free_count;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic res_nop;
        logic res_empty;
        logic alloc_pop;
        logic alloc_fin;
        logic div_start;
        logic free_fin;
        logic init_chk;
        logic fill_step;
        logic emit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] operation;
        logic       depth_zero;
        logic       div_done;
        logic       init_ok;
        logic       fill_last;
    } sts_t;

endpackage

`default_nettype wire

/* sv/fixed_block_stack_allocator.sv */
// Allocate runs decode, stack read and result (straight to result on an empty stack);
// unused operation 3 runs decode and result; free runs the bit-serial remainder check,
// one bit per cycle over 25 bits; initialize divides, then pushes the blocks in turn.
// Throughput: one operation at a time; the next word is taken once a result is queued.
// Reset: async, active low; config registers clear to zero, stack empty,
// stack memory contents undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_stack_allocator #(
    parameter int MAX_BLOCKS  = fba_pkg::MAX_BLOCKS_DEF,
    parameter int OFFSET_BITS = fba_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [fba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fba_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire fba_pkg::req_t                 in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output fba_pkg::rsp_t                      out_data
);

    fba_pkg::cmd_t cmd;
    fba_pkg::sts_t sts;

    fba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    fba_dpath #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

/* sv/fba_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module fba_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [fba_pkg::DIV_W-1:0] dividend,
    input  wire logic [fba_pkg::DIV_W-1:0] divisor,
    output logic                          done,
    output logic [fba_pkg::DIV_W-1:0]     quotient,
    output logic [fba_pkg::DIV_W-1:0]     remainder
);

    localparam int W     = fba_pkg::DIV_W;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     divisor_reg;
    logic [W:0]       shifted;
    logic [W:0]       trial;
    logic             take;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[W-1]};
        trial   = shifted - {1'b0, divisor_reg};
        take    = !trial[W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
            cnt_reg     <= CNT_W'(W - 1);
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[W-2:0], take};
            rem_reg <= take ? trial[W-1:0] : shifted[W-1:0];
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* sv/fba_dpath.sv */
// Allocator datapath: config registers, free stack memory, depth, checks, result.
`timescale 1ns / 1ps
`default_nettype none

module fba_dpath #(
    parameter int MAX_BLOCKS  = fba_pkg::MAX_BLOCKS_DEF,
    parameter int OFFSET_BITS = fba_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [fba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fba_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire fba_pkg::req_t                 in_data,
    input  wire fba_pkg::cmd_t                 cmd,
    output fba_pkg::sts_t                      sts,
    output fba_pkg::rsp_t                      out_data
);

    localparam int DW      = fba_pkg::DIV_W;
    localparam int DEPTH_W = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int PROD_W  = DEPTH_W + 1 + DW;
    localparam logic [32:0] OFFSET_LIMIT = 33'(1) << OFFSET_BITS;

    logic [31:0]            base_reg;
    logic [DW-1:0]          buffer_reg;
    logic [DW-1:0]          block_reg;
    logic [DEPTH_W-1:0]     depth_reg;
    logic [DEPTH_W-1:0]     depth_next;
    logic [1:0]             op_reg;
    logic [31:0]            offset_reg;
    logic [OFFSET_BITS-1:0] rd_data_reg;
    logic [2:0]             res_status_reg;
    logic [31:0]            res_given_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic                   range_bad_reg;
    logic [DEPTH_W-1:0]     fill_idx_reg;
    logic [DW-1:0]          fill_val_reg;
    fba_pkg::rsp_t          out_data_reg;

    logic [OFFSET_BITS-1:0] stack_mem [MAX_BLOCKS];

    logic                   div_done;
    logic [DW-1:0]          div_quo;
    logic [DW-1:0]          div_rem;
    logic [DW-1:0]          div_dividend;
    logic [DEPTH_W-1:0]     depth_m1;
    logic                   addr_bad;
    logic                   all_free;
    logic                   free_ok;
    logic                   init_ok;
    logic                   fill_last;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [OFFSET_BITS-1:0] mem_wdata;

    fba_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (block_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // free divides the offset (range check guarantees it fits), init the buffer size
    assign div_dividend = (op_reg == fba_pkg::OP_FREE) ? offset_reg[DW-1:0] : buffer_reg;

    always_comb
    begin
        depth_m1  = depth_reg - 1'b1;
        addr_bad  = range_bad_reg || (div_rem != '0);
        // depth >= min(buffer/block, MAX_BLOCKS) without a second division
        all_free  = (depth_reg >= DEPTH_W'(MAX_BLOCKS)) || (prod_reg > PROD_W'(buffer_reg));
        free_ok   = !addr_bad && !all_free;
        init_ok   = !((block_reg == '0) || (block_reg > buffer_reg) ||
                      (33'(buffer_reg) > OFFSET_LIMIT) || (div_rem != '0) ||
                      (div_quo > DW'(MAX_BLOCKS)));
        fill_last = (DW'(fill_idx_reg) + DW'(1)) == div_quo;

        mem_we    = (cmd.free_fin && free_ok) || cmd.fill_step;
        mem_waddr = cmd.fill_step ? fill_idx_reg[ADDR_W-1:0] : depth_reg[ADDR_W-1:0];
        mem_wdata = cmd.fill_step ? OFFSET_BITS'(fill_val_reg) : offset_reg[OFFSET_BITS-1:0];

        depth_next = depth_reg;
        if (cmd.alloc_pop)
        begin
            depth_next = depth_m1;
        end
        else if (cmd.free_fin && free_ok)
        begin
            depth_next = depth_reg + 1'b1;
        end
        else if (cmd.fill_step && fill_last)
        begin
            depth_next = DEPTH_W'(div_quo);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            buffer_reg <= '0;
            block_reg  <= '0;
            depth_reg  <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    fba_pkg::CFG_BASE_ADDRESS: base_reg   <= cfg_wdata;
                    fba_pkg::CFG_BUFFER_BYTES: buffer_reg <= cfg_wdata[DW-1:0];
                    fba_pkg::CFG_BLOCK_BYTES:  block_reg  <= cfg_wdata[DW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.alloc_pop)
        begin
            rd_data_reg <= stack_mem[depth_m1[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_data.operation;
            offset_reg <= in_data.block_address - base_reg;
        end
        if (cmd.div_start)
        begin
            prod_reg      <= (PROD_W'(depth_reg) + PROD_W'(1)) * PROD_W'(block_reg);
            range_bad_reg <= (block_reg == '0) ||
                             ({1'b0, offset_reg} + 33'(block_reg) > 33'(buffer_reg)) ||
                             ({1'b0, offset_reg} >= OFFSET_LIMIT);
        end
        if (cmd.res_nop)
        begin
            res_status_reg <= fba_pkg::ST_OK;
            res_given_reg  <= '0;
        end
        if (cmd.res_empty)
        begin
            res_status_reg <= fba_pkg::ST_EMPTY;
            res_given_reg  <= '0;
        end
        if (cmd.alloc_fin)
        begin
            res_status_reg <= fba_pkg::ST_OK;
            res_given_reg  <= base_reg + 32'(rd_data_reg);
        end
        if (cmd.free_fin)
        begin
            res_status_reg <= addr_bad ? fba_pkg::ST_BAD_ADDRESS :
                              all_free ? fba_pkg::ST_ALL_FREE : fba_pkg::ST_OK;
            res_given_reg  <= '0;
        end
        if (cmd.init_chk)
        begin
            res_status_reg <= init_ok ? fba_pkg::ST_OK : fba_pkg::ST_BAD_CONFIG;
            res_given_reg  <= '0;
            fill_idx_reg   <= '0;
            fill_val_reg   <= buffer_reg - block_reg;
        end
        if (cmd.fill_step)
        begin
            fill_idx_reg <= fill_idx_reg + 1'b1;
            fill_val_reg <= fill_val_reg - block_reg;
        end
        if (cmd.emit)
        begin
            out_data_reg.status        <= res_status_reg;
            out_data_reg.given_address <= res_given_reg;
            out_data_reg.free_count    <= fba_pkg::free_count_t'(depth_reg);
        end
    end

    assign sts.operation  = op_reg;
    assign sts.depth_zero = (depth_reg == '0);
    assign sts.div_done   = div_done;
    assign sts.init_ok    = init_ok;
    assign sts.fill_last  = fill_last;
    assign out_data       = out_data_reg;

endmodule

`default_nettype wire

/* sv/fba_ctrl.sv */
// Allocator controller: sequences one operation at a time and drives the handshakes.
`timescale 1ns / 1ps
`default_nettype none

module fba_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    input  wire fba_pkg::sts_t sts,
    output fba_pkg::cmd_t      cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DECODE   = 8'b0000_0010,
        S_ALLOC_RD = 8'b0000_0100,
        S_DIV_WAIT = 8'b0000_1000,
        S_FREE_FIN = 8'b0001_0000,
        S_INIT_CHK = 8'b0010_0000,
        S_FILL     = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.operation)
                    fba_pkg::OP_ALLOC:
                    begin
                        if (sts.depth_zero)
                        begin
                            cmd.res_empty = 1'b1;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            cmd.alloc_pop = 1'b1;
                            state_next    = S_ALLOC_RD;
                        end
                    end
                    fba_pkg::OP_FREE, fba_pkg::OP_INIT:
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV_WAIT;
                    end
                    default:
                    begin
                        cmd.res_nop = 1'b1;
                        state_next  = S_DONE;
                    end
                endcase
            end
            S_ALLOC_RD:
            begin
                cmd.alloc_fin = 1'b1;
                state_next    = S_DONE;
            end
            S_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = (sts.operation == fba_pkg::OP_FREE) ? S_FREE_FIN : S_INIT_CHK;
                end
            end
            S_FREE_FIN:
            begin
                cmd.free_fin = 1'b1;
                state_next   = S_DONE;
            end
            S_INIT_CHK:
            begin
                cmd.init_chk = 1'b1;
                state_next   = sts.init_ok ? S_FILL : S_DONE;
            end
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = cmd.emit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire
